// ===== rtl/drawbar_additive_voice_core_defines.svh =====
`ifndef DRAWBAR_ADDITIVE_VOICE_CORE_DEFINES_SVH
`define DRAWBAR_ADDITIVE_VOICE_CORE_DEFINES_SVH

// Checks a consequence in the same cycle as its trigger.
`define DAV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its trigger.
`define DAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dav_pkg.sv =====
package dav_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int NUM_DRAWBARS    = 9;

   localparam int OPCODE_W  = 2;
   localparam int PITCH_W   = 24;
   localparam int SAMPLE_W  = 16;
   localparam int STAGE_W   = 2;
   localparam int LEVEL_W   = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 36;
   localparam int DRAWBARS_W  = 36;
   localparam int HZ_W        = 34;
   localparam int HZ_LO_W     = 17;
   localparam int STEP_W      = 16;
   localparam int SETTING_W   = 4;

   localparam int PHASE_W     = 32;
   localparam int MULT_W      = 5;
   localparam int ANG_W       = PHASE_W + MULT_W;
   localparam int NOTE_LO_W   = PITCH_W + HZ_LO_W;
   localparam int NOTE_HI_W   = PITCH_W + (HZ_W - HZ_LO_W);
   localparam int NOTE_SUM_W  = PITCH_W + HZ_W;
   localparam int INC_SHIFT   = 24;

   localparam int QSINE_W     = 15;
   localparam int SINE_HALF_W = SINE_TABLE_BITS - 1;
   localparam int SINE_QUARTER = 2 ** (SINE_TABLE_BITS - 2);

   // Partial sum holds nine full-scale terms weighted up to 2^8.
   localparam int ACC_W      = 28;
   localparam int PROD_W     = ACC_W + LEVEL_W + 1;
   localparam int DIV_SHIFT  = 23;
   localparam int DIV_BY     = 9;
   localparam int XW         = PROD_W - DIV_SHIFT;
   localparam logic [XW-1:0] RECIP_M = XW'((2 ** XW) / DIV_BY);

   localparam int DB_IDX_W = (NUM_DRAWBARS > 1) ? $clog2(NUM_DRAWBARS) : 1;
   localparam int CNT_W    = $clog2(NUM_DRAWBARS + 1);

   localparam logic [LEVEL_W-1:0]   ENV_PEAK    = 16'h8000;
   localparam logic [SETTING_W-1:0] MAX_SETTING = 4'd8;

   localparam logic [DRAWBARS_W-1:0] DRAWBARS_RESET = '0;
   localparam logic [HZ_W-1:0]       HZ_RESET       = 34'd5864062015;
   localparam logic [STEP_W-1:0]     STEP_RESET     = 16'd1;

   localparam logic [MULT_W-1:0] HALF_MULT [9] = '{
      5'd1, 5'd3, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd16
   };

   localparam logic [63:0] K_A = 64'd1686629713;
   localparam logic [63:0] K_B = 64'd693598668;
   localparam logic [63:0] K_C = 64'd85569306;
   localparam logic [63:0] K_D = 64'd5026995;
   localparam logic [63:0] K_E = 64'd172272;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK     = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   typedef enum logic [STAGE_W-1:0] {
      ST_ATTACK  = 2'd0,
      ST_SUSTAIN = 2'd1,
      ST_RELEASE = 2'd2
   } env_stage_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRAWBARS = 2'd0,
      CSR_HZ_TO_PHASE = 2'd1,
      CSR_ATTACK = 2'd2,
      CSR_RELEASE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_NOTE_LO,
      S_NOTE_HI,
      S_PART,
      S_SCALE,
      S_RECIP,
      S_CORR,
      S_FINISH
   } dav_state_type;

   typedef struct packed {
      logic                capture;
      logic                decode;
      logic                note_lo;
      logic                note_hi;
      logic                part_run;
      logic                rd_en;
      logic [DB_IDX_W-1:0] rd_sel;
      logic                scale;
      logic                recip;
      logic                corr;
      logic                load_out;
   } dav_cmd_type;

   typedef struct packed {
      opcode_type op;
   } dav_status_type;

   typedef logic [QSINE_W-1:0] qsine_type [SINE_QUARTER];

   // Quarter-wave sine entry in Q15, from the Q30 odd polynomial.
   function automatic logic [QSINE_W-1:0] sine_q(input int unsigned j);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] q;
      z  = 64'(j) << (32 - SINE_TABLE_BITS);
      z2 = (z * z) >> 30;
      r  = K_E;
      r  = K_D - ((z2 * r) >> 30);
      r  = K_C - ((z2 * r) >> 30);
      r  = K_B - ((z2 * r) >> 30);
      r  = K_A - ((z2 * r) >> 30);
      s  = (z * r) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[QSINE_W-1:0];
   endfunction

   function automatic qsine_type build_qsine();
      qsine_type t;
      for (int k = 0; k < SINE_QUARTER; k++) begin
         t[k] = sine_q(k);
      end
      return t;
   endfunction

   localparam qsine_type QSINE = build_qsine();
   localparam logic [QSINE_W-1:0] SINE_PEAK_Q = sine_q(SINE_QUARTER);

endpackage

// ===== rtl/dav_req_if.sv =====
interface dav_req_if import dav_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [PITCH_W-1:0]         pitch;
   logic signed [SAMPLE_W-1:0] mix_in;

   modport source (output valid, output opcode, output pitch, output mix_in, input ready);
   modport sink (input valid, input opcode, input pitch, input mix_in, output ready);
endinterface

// ===== rtl/dav_rsp_if.sv =====
interface dav_rsp_if import dav_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic [STAGE_W-1:0]         envelope_stage;
   logic [LEVEL_W-1:0]         envelope_level;

   modport source (output valid, output sample_out, output envelope_stage,
                   output envelope_level, input ready);
   modport sink (input valid, input sample_out, input envelope_stage,
                 input envelope_level, output ready);
endinterface

// ===== rtl/dav_ctrl.sv =====
`include "drawbar_additive_voice_core_defines.svh"

module dav_ctrl import dav_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  dav_status_type status,
   output dav_cmd_type    cmd
);

   localparam logic [CNT_W-1:0] PART_LAST = CNT_W'(NUM_DRAWBARS);

   dav_state_type    state_ff, state_in;
   logic [CNT_W-1:0] part_cnt_ff, part_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         part_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         part_cnt_ff  <= part_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      part_cnt_in  = part_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rd_sel   = part_cnt_ff[DB_IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode  = 1'b1;
            part_cnt_in = '0;
            case (status.op)
               OP_TICK:    state_in = S_PART;
               OP_NOTE_ON: state_in = S_NOTE_LO;
               default:    state_in = S_FINISH;
            endcase
         end
         S_NOTE_LO: begin
            cmd.note_lo = 1'b1;
            state_in    = S_NOTE_HI;
         end
         S_NOTE_HI: begin
            cmd.note_hi = 1'b1;
            state_in    = S_FINISH;
         end
         S_PART: begin
            // One drawbar is read per cycle; the last cycle only drains the
            // table read into the accumulator.
            cmd.part_run = 1'b1;
            cmd.rd_en    = (part_cnt_ff < PART_LAST);
            if (part_cnt_ff == PART_LAST) begin
               state_in = S_SCALE;
            end else begin
               part_cnt_in = part_cnt_ff + 1'b1;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_RECIP;
         end
         S_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = S_CORR;
         end
         S_CORR: begin
            cmd.corr = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `DAV_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready,
      state_ff == S_DECODE, "accepted beat did not enter decode")
   `DAV_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load_out,
      !rsp_valid_ff || rsp_ready, "pending result overwritten")
   `DAV_ASSERT_SAME(a_part_range, clock, reset, state_ff == S_PART,
      part_cnt_ff <= PART_LAST, "partial counter out of range")
   `DAV_ASSERT_NEXT(a_loop_exit, clock, reset, state_ff == S_PART && part_cnt_ff == PART_LAST,
      state_ff == S_SCALE, "partial loop did not exit to scaling")

endmodule

// ===== rtl/dav_datapath.sv =====
module dav_datapath import dav_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [PITCH_W-1:0]         req_pitch,
   input  logic signed [SAMPLE_W-1:0] req_mix_in,
   input  dav_cmd_type                cmd,
   output dav_status_type             status,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic [STAGE_W-1:0]         rsp_envelope_stage,
   output logic [LEVEL_W-1:0]         rsp_envelope_level
);

   localparam logic [SINE_HALF_W-1:0] QUARTER_IDX = SINE_HALF_W'(SINE_QUARTER);
   localparam int SUM_W = XW + 2;

   // Configuration registers.
   logic [DRAWBARS_W-1:0] drawbars_ff, drawbars_in;
   logic [HZ_W-1:0]       hz_ff, hz_in;
   logic [STEP_W-1:0]     atk_ff, atk_in;
   logic [STEP_W-1:0]     rel_ff, rel_in;

   // Voice state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] inc_ff, inc_in;
   logic [LEVEL_W-1:0] vol_ff, vol_in;
   env_stage_type      stage_ff, stage_in;
   logic               tap_vld_ff, tap_vld_in;

   // Captured beat and working registers.
   opcode_type                 op_ff, op_in;
   logic [PITCH_W-1:0]         pitch_ff, pitch_in;
   logic signed [SAMPLE_W-1:0] mix_ff, mix_in;
   logic [NOTE_LO_W-1:0]       note_lo_ff, note_lo_in;
   logic [QSINE_W-1:0]         rom_q_ff, rom_q_in;
   logic                       rom_neg_ff, rom_neg_in;
   logic [SETTING_W-1:0]       weight_ff, weight_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic [XW-1:0]              x_ff, x_in;
   logic [2*XW-1:0]            mq_ff, mq_in;
   logic [XW-1:0]              q_ff, q_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [STAGE_W-1:0]         stage_out_ff, stage_out_in;
   logic [LEVEL_W-1:0]         level_ff, level_in;

   // Combinational helpers.
   logic [MULT_W-1:0]          mult_sel;
   logic [ANG_W-1:0]           ang_prod;
   logic [SINE_TABLE_BITS-1:0] sin_idx;
   logic [SINE_HALF_W-1:0]     half_idx;
   logic [SINE_HALF_W-1:0]     quart_idx;
   logic [QSINE_W-1:0]         rom_q;
   logic [SETTING_W-1:0]       set_raw;
   logic signed [SAMPLE_W-1:0] sval;
   logic signed [ACC_W-1:0]    term;
   logic [NOTE_HI_W-1:0]       note_hi;
   logic [NOTE_SUM_W-1:0]      note_sum;
   logic [LEVEL_W:0]           env_sum;
   logic [PROD_W-1:0]          mag;
   logic [XW-1:0]              qest;
   logic [XW+3:0]              nine_q;
   logic [XW-1:0]              rem;
   logic signed [XW:0]         voice;
   logic signed [SUM_W-1:0]    mixed;
   logic signed [SAMPLE_W-1:0] sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         drawbars_ff <= DRAWBARS_RESET;
         hz_ff       <= HZ_RESET;
         atk_ff      <= STEP_RESET;
         rel_ff      <= STEP_RESET;
         phase_ff    <= '0;
         inc_ff      <= '0;
         vol_ff      <= '0;
         stage_ff    <= ST_RELEASE;
         tap_vld_ff  <= 1'b0;
      end else begin
         drawbars_ff <= drawbars_in;
         hz_ff       <= hz_in;
         atk_ff      <= atk_in;
         rel_ff      <= rel_in;
         phase_ff    <= phase_in;
         inc_ff      <= inc_in;
         vol_ff      <= vol_in;
         stage_ff    <= stage_in;
         tap_vld_ff  <= tap_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pitch_ff     <= pitch_in;
      mix_ff       <= mix_in;
      note_lo_ff   <= note_lo_in;
      rom_q_ff     <= rom_q_in;
      rom_neg_ff   <= rom_neg_in;
      weight_ff    <= weight_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      x_ff         <= x_in;
      mq_ff        <= mq_in;
      q_ff         <= q_in;
      sample_ff    <= sample_in;
      stage_out_ff <= stage_out_in;
      level_ff     <= level_in;
   end

   // Configuration writes.
   always_comb begin
      drawbars_in = drawbars_ff;
      hz_in       = hz_ff;
      atk_in      = atk_ff;
      rel_in      = rel_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_DRAWBARS:    drawbars_in = csr_wdata[DRAWBARS_W-1:0];
            CSR_HZ_TO_PHASE: hz_in       = csr_wdata[HZ_W-1:0];
            CSR_ATTACK:      atk_in      = csr_wdata[STEP_W-1:0];
            CSR_RELEASE:     rel_in      = csr_wdata[STEP_W-1:0];
            default: begin
               drawbars_in = drawbars_ff;
            end
         endcase
      end
   end

   // Sine lookup for the drawbar selected this cycle.
   always_comb begin
      mult_sel = HALF_MULT[cmd.rd_sel];
      ang_prod = phase_ff * mult_sel;
      sin_idx  = ang_prod[PHASE_W -: SINE_TABLE_BITS];
      half_idx = sin_idx[SINE_HALF_W-1:0];
      // Past the quarter point the wave is mirrored; modular negation
      // gives the half period minus the index.
      quart_idx = (half_idx > QUARTER_IDX) ? -half_idx : half_idx;
      rom_q = (quart_idx == QUARTER_IDX) ? SINE_PEAK_Q
                                         : QSINE[quart_idx[SINE_HALF_W-2:0]];
      set_raw = drawbars_ff[{cmd.rd_sel, 2'b00} +: SETTING_W];
   end

   always_comb begin
      sval = rom_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
      term = ACC_W'(sval) <<< weight_ff;

      note_hi  = pitch_ff * hz_ff[HZ_W-1:HZ_LO_W];
      note_sum = NOTE_SUM_W'(note_lo_ff) + (NOTE_SUM_W'(note_hi) << HZ_LO_W);

      env_sum = {1'b0, vol_ff} + {1'b0, atk_ff};

      mag    = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      qest   = mq_ff[2*XW-1:XW];
      nine_q = {qest, 3'b000} + (XW+4)'(qest);
      rem    = x_ff - nine_q[XW-1:0];

      voice = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      mixed = SUM_W'(mix_ff) + SUM_W'(voice);
      if (mixed[SUM_W-1:SAMPLE_W-1] == '0 || mixed[SUM_W-1:SAMPLE_W-1] == '1) begin
         sat = mixed[SAMPLE_W-1:0];
      end else if (mixed[SUM_W-1]) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      op_in        = op_ff;
      pitch_in     = pitch_ff;
      mix_in       = mix_ff;
      note_lo_in   = note_lo_ff;
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      vol_in       = vol_ff;
      stage_in     = stage_ff;
      rom_q_in     = rom_q;
      rom_neg_in   = sin_idx[SINE_TABLE_BITS-1];
      weight_in    = (set_raw > MAX_SETTING) ? MAX_SETTING : set_raw;
      tap_vld_in   = cmd.part_run && cmd.rd_en && (set_raw != '0);
      acc_in       = tap_vld_ff ? acc_ff + term : acc_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      x_in         = x_ff;
      mq_in        = mq_ff;
      q_in         = q_ff;
      sample_in    = sample_ff;
      stage_out_in = stage_out_ff;
      level_in     = level_ff;

      if (cmd.capture) begin
         op_in    = opcode_type'(req_opcode);
         pitch_in = req_pitch;
         mix_in   = req_mix_in;
      end

      if (cmd.decode) begin
         acc_in = '0;
         case (op_ff)
            OP_TICK: begin
               case (stage_ff)
                  ST_ATTACK: begin
                     if (vol_ff < ENV_PEAK) begin
                        vol_in = (env_sum > {1'b0, ENV_PEAK}) ? ENV_PEAK
                                                              : env_sum[LEVEL_W-1:0];
                     end else begin
                        vol_in   = ENV_PEAK;
                        stage_in = ST_SUSTAIN;
                     end
                  end
                  ST_RELEASE: begin
                     vol_in = (vol_ff > rel_ff) ? vol_ff - rel_ff : '0;
                  end
                  default: begin
                     vol_in = vol_ff;
                  end
               endcase
            end
            OP_NOTE_OFF: stage_in = ST_RELEASE;
            default: begin
               stage_in = stage_ff;
            end
         endcase
      end

      if (cmd.note_lo) begin
         note_lo_in = pitch_ff * hz_ff[HZ_LO_W-1:0];
      end

      if (cmd.note_hi) begin
         inc_in   = note_sum[INC_SHIFT +: PHASE_W];
         phase_in = '0;
         vol_in   = '0;
         stage_in = ST_ATTACK;
      end

      if (cmd.scale) begin
         prod_in  = acc_ff * $signed({1'b0, vol_ff});
         phase_in = phase_ff + inc_ff;
      end

      if (cmd.recip) begin
         neg_in = prod_ff[PROD_W-1];
         x_in   = mag[PROD_W-1:DIV_SHIFT];
         mq_in  = mag[PROD_W-1:DIV_SHIFT] * RECIP_M;
      end

      // The reciprocal estimate is at most one low.
      if (cmd.corr) begin
         q_in = (rem >= XW'(DIV_BY)) ? qest + 1'b1 : qest;
      end

      if (cmd.load_out) begin
         sample_in    = (op_ff == OP_TICK) ? sat : mix_ff;
         stage_out_in = stage_ff;
         level_in     = vol_ff;
      end
   end

   assign status.op          = op_ff;
   assign rsp_sample_out     = sample_ff;
   assign rsp_envelope_stage = stage_out_ff;
   assign rsp_envelope_level = level_ff;

endmodule

// ===== rtl/drawbar_additive_voice_core.sv =====
// Channel    Dir  Handshake     Payload
// req_chan   in   valid/ready   opcode, pitch, mix_in
// rsp_chan   out  valid/ready   sample_out, envelope_stage, envelope_level
// csr_*      in   csr_wen       csr_index, csr_wdata
//
// A sample tick is accepted, decoded, run through the drawbars via the registered sine read
// with a drain step, scaled by the envelope, divided by nine (S_SCALE, S_RECIP, S_CORR) and
// loaded. Note on splits the pitch multiply (S_NOTE_LO, S_NOTE_HI); other beats go to S_FINISH.
// Reset (synchronous, active high) restores register defaults, clears phase and level,
// and leaves the envelope in release. One beat is in work at a time; a new beat is accepted
// while a result waits, and the next result is held in its last cycle until that one is taken.
module drawbar_additive_voice_core import dav_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   dav_req_if.sink                req_chan,
   dav_rsp_if.source              rsp_chan,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dav_cmd_type    cmd;
   dav_status_type status;

   dav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dav_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_chan.opcode),
      .req_pitch          (req_chan.pitch),
      .req_mix_in         (req_chan.mix_in),
      .cmd                (cmd),
      .status             (status),
      .rsp_sample_out     (rsp_chan.sample_out),
      .rsp_envelope_stage (rsp_chan.envelope_stage),
      .rsp_envelope_level (rsp_chan.envelope_level)
   );

endmodule
